@@ rtl/pbr_pkg.sv @@
// Package for the polyline Bresenham rasterizer.
// Holds the coordinate widths and the request and result struct types.
// No dependencies.
package pbr_pkg;

  // Coordinate bits that take part in the walk; upper field bits are ignored.
  localparam int COORD_BITS = 6;
  // Fixed width of the coordinate fields on the ports.
  localparam int FIELD_W = 6;
  // Error term width: holds twice the largest delta with sign and margin.
  localparam int ERR_W = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic [FIELD_W-1:0] waypoint_x;
    logic [FIELD_W-1:0] waypoint_y;
    logic               path_end;
  } pbr_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] point_x;
    logic [FIELD_W-1:0] point_y;
    logic               run_last;
    logic               path_last;
  } pbr_out_t;

  // Fixed description of one segment, set up when the request is taken.
  typedef struct packed {
    coord_t dx;
    coord_t dy;
    logic   x_neg;
    logic   y_neg;
  } pbr_seg_t;

endpackage

@@ rtl/pbr_step.sv @@
// Shared Bresenham step unit: advances the cursor and error term by one point.
// Depends on pbr_pkg.
module pbr_step
  import pbr_pkg::*;
(
  input  pbr_seg_t seg_i,
  input  coord_t   x_i,
  input  coord_t   y_i,
  input  err_t     err_i,
  output coord_t   x_o,
  output coord_t   y_o,
  output err_t     err_o
);

  err_t dx_s;
  err_t dy_s;
  err_t e2;
  logic step_x;
  logic step_y;
  err_t err_x;

  assign dx_s = $signed(ERR_W'(seg_i.dx));
  assign dy_s = $signed(ERR_W'(seg_i.dy));
  assign e2   = err_i <<< 1;

  // Both decisions look at the error term from before this step.
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;

  assign err_x = step_x ? err_i - dy_s : err_i;
  assign err_o = step_y ? err_x + dx_s : err_x;

  assign x_o = !step_x ? x_i : (seg_i.x_neg ? x_i - coord_t'(1) : x_i + coord_t'(1));
  assign y_o = !step_y ? y_i : (seg_i.y_neg ? y_i - coord_t'(1) : y_i + coord_t'(1));

endmodule

@@ rtl/pbr_out_reg.sv @@
// Output holding register for result points, with valid and stall.
// Depends on pbr_pkg.
module pbr_out_reg
  import pbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  input  pbr_out_t push_data_i,
  output logic     push_ready_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pbr_out_t out_data_o
);

  logic     valid_q;
  logic     valid_d;
  pbr_out_t data_q;

  // The slot takes a new point when empty or when its point leaves now.
  assign push_ready_o = !valid_q || !out_stall_i;
  assign valid_d      = push_ready_o ? push_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ready_o && push_valid_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/polyline_bresenham_rasterizer.sv @@
// Polyline Bresenham rasterizer: one grid point per cycle from a shared step unit,
// unless the output stalls. A request continuing a path walks its max(|dx|,|dy|) segment
// points, sends the final point if it ends the path and goes back to idle; a new request
// is taken only in idle. Each point passes the output register before it appears.
// Reset clears the stored vertex to (0,0) and starts a new path.
// Depends on pbr_pkg, pbr_step and pbr_out_reg.
module polyline_bresenham_rasterizer
  import pbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pbr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pbr_out_t out_data_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state_q, state_d;
  coord_t     prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic       have_prev_q, have_prev_d;
  coord_t     cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t     tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic       end_q, end_d;
  err_t       err_q, err_d;
  pbr_seg_t   seg_q, seg_d;

  logic     accept;
  coord_t   new_x, new_y;
  coord_t   next_x, next_y;
  err_t     next_err;
  logic     at_tgt;
  logic     push_valid;
  logic     push_ready;
  pbr_out_t push_data;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign new_x      = in_data_i.waypoint_x[COORD_BITS-1:0];
  assign new_y      = in_data_i.waypoint_y[COORD_BITS-1:0];

  pbr_step u_step (
    .seg_i (seg_q),
    .x_i   (cur_x_q),
    .y_i   (cur_y_q),
    .err_i (err_q),
    .x_o   (next_x),
    .y_o   (next_y),
    .err_o (next_err)
  );

  assign at_tgt = (next_x == tgt_x_q) && (next_y == tgt_y_q);

  always_comb begin
    state_d     = state_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    have_prev_d = have_prev_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    end_d       = end_q;
    err_d       = err_q;
    seg_d       = seg_q;
    push_valid  = 1'b0;
    push_data   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cur_x_d     = prev_x_q;
          cur_y_d     = prev_y_q;
          tgt_x_d     = new_x;
          tgt_y_d     = new_y;
          end_d       = in_data_i.path_end;
          prev_x_d    = new_x;
          prev_y_d    = new_y;
          have_prev_d = !in_data_i.path_end;
          seg_d.dx    = (new_x > prev_x_q) ? new_x - prev_x_q : prev_x_q - new_x;
          seg_d.dy    = (new_y > prev_y_q) ? new_y - prev_y_q : prev_y_q - new_y;
          seg_d.x_neg = !(prev_x_q < new_x);
          seg_d.y_neg = !(prev_y_q < new_y);
          err_d       = $signed(ERR_W'(seg_d.dx)) - $signed(ERR_W'(seg_d.dy));
          if (have_prev_q && ((prev_x_q != new_x) || (prev_y_q != new_y))) begin
            state_d = ST_RUN;
          end else if (in_data_i.path_end) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_RUN: begin
        push_valid          = 1'b1;
        push_data.point_x   = FIELD_W'(cur_x_q);
        push_data.point_y   = FIELD_W'(cur_y_q);
        // Without a path end the point before the target closes the request.
        push_data.run_last  = at_tgt && !end_q;
        push_data.path_last = 1'b0;
        if (push_ready) begin
          cur_x_d = next_x;
          cur_y_d = next_y;
          err_d   = next_err;
          if (at_tgt) begin
            state_d = end_q ? ST_FINAL : ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        push_valid          = 1'b1;
        push_data.point_x   = FIELD_W'(tgt_x_q);
        push_data.point_y   = FIELD_W'(tgt_y_q);
        push_data.run_last  = 1'b1;
        push_data.path_last = 1'b1;
        if (push_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    tgt_x_q <= tgt_x_d;
    tgt_y_q <= tgt_y_d;
    end_q   <= end_d;
    err_q   <= err_d;
    seg_q   <= seg_d;
  end

  pbr_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // While walking, the cursor has not yet reached the target.
  a_run_not_at_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((cur_x_q != tgt_x_q) || (cur_y_q != tgt_y_q)))
    else $error("walk running with cursor on target");

  // The final point is only sent for a request that ends the path.
  a_final_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |-> end_q)
    else $error("final point without path end");

  // Twice the error term stays between -3*dy and 3*dx during the walk.
  a_err_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |->
      ((2 * int'(err_q) >= -3 * int'(seg_q.dy)) && (2 * int'(err_q) <= 3 * int'(seg_q.dx))))
    else $error("error term out of range");

  // A path end always closes its request.
  a_path_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.path_last) |-> out_data_o.run_last)
    else $error("path end point without run end");

  // A path end leaves no previous vertex behind.
  a_end_clears_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.path_end) |=> !have_prev_q)
    else $error("previous vertex kept after path end");

endmodule
